// File: hw/rtl/raip_pkg.sv
// ----------------------------------------------------------------------------
// raip_pkg
// Shared types and constants of the radix alphabet integer parser: the
// classified character word carried between front and back, result status
// codes, configuration register indexes and character constants.
// ----------------------------------------------------------------------------
package raip_pkg;

    // Alphabet limits
    localparam int MAX_BASE   = 16;
    localparam int NUM_CHARS  = 16;
    localparam int DIGIT_W    = 4;
    localparam int LEN_W      = 5;

    // Result status codes
    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_BAD_ALPHABET = 2'd1;
    localparam logic [1:0] STATUS_RANGE        = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALPHA_LOW  = 2'd0;
    localparam logic [1:0] CFG_ALPHA_HIGH = 2'd1;
    localparam logic [1:0] CFG_ALPHA_LEN  = 2'd2;

    // Character constants
    localparam logic [7:0] CHAR_TAB     = 8'd9;
    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_SPACE   = 8'd32;
    localparam logic [7:0] CHAR_DEL     = 8'd127;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_MINUS   = 8'h2D;

    // Magnitude limit of a negative signed 32-bit result
    localparam logic [31:0] MAG_NEG_MAX = 32'd2147483648;

    // One classified character word
    typedef struct packed {
        logic               start;
        logic               alpha_ok;
        logic               is_space;
        logic               is_minus;
        logic               is_plus;
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
    } raip_entry_t;

endpackage

// File: hw/rtl/radix_alphabet_integer_parser_top.sv
// An accepted character is written into the queue; the parse step loads its
// result into the output register as it takes that word. Throughput: one
// character per cycle without stalls, set by the combinational multiply-add
// of the parse sequencer; the queue lets input and output stall apart.
// Reset clears the alphabet registers, the parse state (waiting for a start),
// the queue and the output valid flag at once; there is no clearing pass.
// ----------------------------------------------------------------------------
// radix_alphabet_integer_parser_top
// Signed integer parser over a byte stream with a configurable digit
// alphabet: configuration registers, classifying front, word queue and
// parse back end.
// ----------------------------------------------------------------------------
module radix_alphabet_integer_parser_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          ch,
    input  logic                start_req,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  value,
    output logic [1:0]          status,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [63:0]         cfg_data
);
    import raip_pkg::*;

    logic [63:0]    alpha_low_reg;
    logic [63:0]    alpha_high_reg;
    logic [4:0]     alpha_len_reg;

    logic           push;
    raip_entry_t    push_entry;
    logic           queue_full;
    logic           head_valid;
    raip_entry_t    head_entry;
    logic           pop;

    // Write configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_low_reg  <= '0;
            alpha_high_reg <= '0;
            alpha_len_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALPHA_LOW:  alpha_low_reg  <= cfg_data;
                CFG_ALPHA_HIGH: alpha_high_reg <= cfg_data;
                CFG_ALPHA_LEN:  alpha_len_reg  <= cfg_data[4:0];
                default:        ;
            endcase
        end
    end

    // Classify incoming characters
    raip_front u_front (
        .in_valid     (in_valid),
        .queue_full   (queue_full),
        .ch           (ch),
        .start_req    (start_req),
        .alpha_low    (alpha_low_reg),
        .alpha_high   (alpha_high_reg),
        .alpha_length (alpha_len_reg),
        .in_stall     (in_stall),
        .push         (push),
        .push_entry   (push_entry)
    );

    // Buffer classified words
    raip_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (queue_full),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    // Parse and deliver results
    raip_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_entry   (head_entry),
        .alpha_length (alpha_len_reg),
        .out_stall    (out_stall),
        .pop          (pop),
        .out_valid    (out_valid),
        .value        (value),
        .status       (status)
    );

endmodule

// File: hw/rtl/raip_front.sv
// ----------------------------------------------------------------------------
// raip_front
// Accepts character words and classifies them against the configured
// alphabet: whitespace, sign characters, digit index and, on start words,
// the validity of the alphabet itself.
// ----------------------------------------------------------------------------
module raip_front (
    input  logic                        in_valid,
    input  logic                        queue_full,
    input  logic [7:0]                  ch,
    input  logic                        start_req,
    input  logic [63:0]                 alpha_low,
    input  logic [63:0]                 alpha_high,
    input  logic [4:0]                  alpha_length,
    output logic                        in_stall,
    output logic                        push,
    output raip_pkg::raip_entry_t       push_entry
);
    import raip_pkg::*;

    logic [7:0]         chars [NUM_CHARS];
    logic [LEN_W-1:0]   used_len;
    logic               alpha_ok;
    logic               hit;
    logic [DIGIT_W-1:0] hit_idx;

    // Split the two alphabet registers into digit characters
    always_comb
    begin
        for (int k = 0; k < NUM_CHARS / 2; k++)
        begin
            chars[k]                 = alpha_low[8*k +: 8];
            chars[k + NUM_CHARS / 2] = alpha_high[8*k +: 8];
        end
    end

    // Check the alphabet: length, forbidden characters, duplicates
    always_comb
    begin
        alpha_ok = (alpha_length >= LEN_W'(2)) && (alpha_length <= LEN_W'(MAX_BASE));
        for (int i = 0; i < NUM_CHARS; i++)
        begin
            if (LEN_W'(i) < alpha_length)
            begin
                if (chars[i] <= CHAR_SPACE || chars[i] >= CHAR_DEL ||
                    chars[i] == CHAR_PLUS || chars[i] == CHAR_MINUS)
                    alpha_ok = 1'b0;
                for (int j = i + 1; j < NUM_CHARS; j++)
                begin
                    if (LEN_W'(j) < alpha_length && chars[j] == chars[i])
                        alpha_ok = 1'b0;
                end
            end
        end
    end

    // Look up the digit index; the lowest matching digit wins
    assign used_len = (alpha_length > LEN_W'(NUM_CHARS)) ? LEN_W'(NUM_CHARS) : alpha_length;

    always_comb
    begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = NUM_CHARS - 1; i >= 0; i--)
        begin
            if (LEN_W'(i) < used_len && chars[i] == ch)
            begin
                hit     = 1'b1;
                hit_idx = DIGIT_W'(i);
            end
        end
    end

    // Build the classified word and push it when the queue has room
    always_comb
    begin
        push_entry.start    = start_req;
        push_entry.alpha_ok = alpha_ok;
        push_entry.is_space = (ch >= CHAR_TAB && ch <= CHAR_CR) || ch == CHAR_SPACE;
        push_entry.is_minus = (ch == CHAR_MINUS);
        push_entry.is_plus  = (ch == CHAR_PLUS);
        push_entry.is_digit = hit;
        push_entry.digit    = hit_idx;
    end

    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

endmodule

// File: hw/rtl/raip_queue.sv
// ----------------------------------------------------------------------------
// raip_queue
// Short first-in first-out queue of classified words between the front and
// the back, so that each side can stall without holding up the other.
// ----------------------------------------------------------------------------
module raip_queue #(
    parameter int DEPTH = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  raip_pkg::raip_entry_t       push_entry,
    input  logic                        pop,
    output logic                        full,
    output logic                        head_valid,
    output raip_pkg::raip_entry_t       head_entry
);
    import raip_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    raip_entry_t        slots [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push)
            slots[wr_ptr_reg] <= push_entry;
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];

    // Count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    // An empty queue has its pointers equal
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("queue empty with pointers apart");

endmodule

// File: hw/rtl/raip_back.sv
// ----------------------------------------------------------------------------
// raip_back
// Parse sequencer: walks whitespace, sign and digit phases for each
// classified word, accumulates value * base + digit with a sticky overflow,
// and places finished results in the output register.
// ----------------------------------------------------------------------------
module raip_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        head_valid,
    input  raip_pkg::raip_entry_t       head_entry,
    input  logic [4:0]                  alpha_length,
    input  logic                        out_stall,
    output logic                        pop,
    output logic                        out_valid,
    output logic signed [31:0]          value,
    output logic [1:0]                  status
);
    import raip_pkg::*;

    localparam logic [1:0] PH_SPACE = 2'd0;
    localparam logic [1:0] PH_SIGN  = 2'd1;
    localparam logic [1:0] PH_DIGIT = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]     phase_reg;
    logic [1:0]     phase_next;
    logic           neg_reg;
    logic           neg_next;
    logic [31:0]    acc_reg;
    logic [31:0]    acc_next;
    logic           ovf_reg;
    logic           ovf_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    logic [31:0]    value_reg;
    logic [1:0]     status_reg;

    logic [31:0]    acc_base;
    logic [36:0]    mul_sum;
    logic           emit;
    logic [31:0]    emit_value;
    logic [1:0]     emit_status;

    // Multiply-add on the accumulator, restarted on a start word
    assign acc_base = head_entry.start ? '0 : acc_reg;
    assign mul_sum  = {5'd0, acc_base} * {32'd0, alpha_length} + {33'd0, head_entry.digit};

    // Step the parse for the word at the head of the queue
    always_comb
    begin
        phase_next  = head_entry.start ? PH_SPACE : phase_reg;
        neg_next    = head_entry.start ? 1'b0 : neg_reg;
        acc_next    = acc_base;
        ovf_next    = head_entry.start ? 1'b0 : ovf_reg;
        emit        = 1'b0;
        emit_value  = '0;
        emit_status = STATUS_OK;
        if (head_entry.start && !head_entry.alpha_ok)
        begin
            phase_next  = PH_DONE;
            emit        = 1'b1;
            emit_status = STATUS_BAD_ALPHABET;
        end
        else if (phase_next != PH_DONE)
        begin
            if (phase_next == PH_SPACE && !head_entry.is_space)
                phase_next = PH_SIGN;
            if (phase_next == PH_SIGN)
            begin
                if (head_entry.is_minus)
                    neg_next = !neg_next;
                else if (!head_entry.is_plus)
                    phase_next = PH_DIGIT;
            end
            if (phase_next == PH_DIGIT)
            begin
                if (head_entry.is_digit)
                begin
                    if (ovf_next || mul_sum[36:32] != '0)
                    begin
                        ovf_next = 1'b1;
                        acc_next = '1;
                    end
                    else
                        acc_next = mul_sum[31:0];
                end
                else
                begin
                    phase_next = PH_DONE;
                    emit       = 1'b1;
                    if (ovf_next || (neg_next && acc_base > MAG_NEG_MAX) ||
                        (!neg_next && acc_base[31]))
                        emit_status = STATUS_RANGE;
                    else
                        emit_value = neg_next ? (32'd0 - acc_base) : acc_base;
                end
            end
        end
    end

    // Take a word whenever the output register is free or being drained
    assign pop = head_valid && (!out_valid_reg || !out_stall);

    // Load or drop the output word
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop && emit)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_DONE;
            neg_reg       <= 1'b0;
            acc_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                neg_reg   <= neg_next;
                acc_reg   <= acc_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (pop && emit)
        begin
            value_reg  <= emit_value;
            status_reg <= emit_status;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = $signed(value_reg);
    assign status    = status_reg;

    // An error result always carries a zero value
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && status_reg != STATUS_OK) |-> (value_reg == '0))
        else $error("error result with nonzero value");

    // Overflow pins the accumulator at all ones
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (acc_reg == '1))
        else $error("overflow without saturated accumulator");

    // A held result is not overwritten by a new word
    a_no_pop_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !pop)
        else $error("word taken while result held");

    // Status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (status_reg == STATUS_OK || status_reg == STATUS_BAD_ALPHABET ||
                           status_reg == STATUS_RANGE))
        else $error("unused status code");

endmodule
